@@ src/dupf_pkg.sv @@
package dupf_pkg;

  localparam int ID_W              = 64;
  localparam int TIME_W            = 63;
  localparam int LINK_W            = 8;
  localparam int DEF_TABLE_ENTRIES = 4096;

  localparam logic [TIME_W-1:0] DEFAULT_WINDOW = 63'd500000000;

  // splitmix64 finalizer
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam int          MIX_S1 = 30;
  localparam int          MIX_S2 = 27;
  localparam int          MIX_S3 = 31;

  typedef enum logic [1:0] {
    VERDICT_INVALID   = 2'd0,
    VERDICT_ACCEPT    = 2'd1,
    VERDICT_DUPLICATE = 2'd2,
    VERDICT_COLLISION = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_LOOKUP,
    ST_EMIT
  } flt_state_t;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_MIX,
    HS_MOD
  } hash_state_t;

  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic [TIME_W-1:0] first_t;
    logic [TIME_W-1:0] last_t;
    logic [LINK_W-1:0] links;
  } entry_t;

  typedef struct packed {
    verdict_t          verdict;
    logic [TIME_W-1:0] first_seen;
    logic [TIME_W-1:0] delay;
    logic [LINK_W-1:0] links;
  } result_t;

endpackage

@@ src/dupf_hash.sv @@
module dupf_hash
  import dupf_pkg::*;
#(
  parameter int  TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  localparam int IdxW          = $clog2(TABLE_ENTRIES)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [ID_W-1:0] key,
  output logic            done,
  output logic [IdxW-1:0] index
);

  localparam bit IsPow2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  // quotient estimate from this reciprocal is low by at most one
  localparam logic [31:0] Recip   = 32'(64'h1_0000_0000 / 64'(TABLE_ENTRIES));
  localparam logic [31:0] Modulus = 32'(TABLE_ENTRIES);

  hash_state_t hstate_r, hstate_nxt;
  logic [2:0]      step_r;
  logic [63:0]     opnd_r;
  logic [63:0]     acc_r;
  logic [71:0]     mix_r;     // zero-padded on top to six 12-bit digits
  logic [IdxW-1:0] rem_r;
  logic [2:0]      digcnt_r;
  logic            mph_r;
  logic [31:0]     v_r;
  logic [31:0]     q_r;
  logic            done_r;
  logic [IdxW-1:0] idx_r;

  logic [1:0]      sub;
  logic            use_c2;
  logic            in_mod;
  logic [63:0]     cnst;
  logic [31:0]     a32;
  logic [31:0]     b32;
  logic [63:0]     prod;
  logic [63:0]     mix_fin;
  logic [31:0]     v32;
  logic [31:0]     rem_est;
  logic [31:0]     rem_fix;

  // step[1:0]: 0 lo*lo, 1 lo*hi, 2 hi*lo, 3 xor-shift; step[2] selects second constant
  assign sub     = step_r[1:0];
  assign use_c2  = step_r[2];
  assign in_mod  = (hstate_r == HS_MOD);
  assign cnst    = use_c2 ? MIX_C2 : MIX_C1;
  // remainder: two multiplier passes per digit, reciprocal then quotient times size
  assign v32     = 32'({rem_r, mix_r[71:60]});
  assign a32     = in_mod ? (mph_r ? q_r : v32) :
                   ((sub == 2'd2) ? opnd_r[63:32] : opnd_r[31:0]);
  assign b32     = in_mod ? (mph_r ? Modulus : Recip) :
                   ((sub == 2'd1) ? cnst[63:32] : cnst[31:0]);
  assign prod    = 64'(a32) * 64'(b32);
  assign mix_fin = acc_r ^ (acc_r >> MIX_S3);

  // estimate stays below twice the table size, one subtract finishes it
  assign rem_est = v_r - prod[31:0];
  assign rem_fix = (rem_est >= Modulus) ? rem_est - Modulus : rem_est;

  always_comb begin
    hstate_nxt = hstate_r;
    unique case (hstate_r)
      HS_IDLE: begin
        if (start) hstate_nxt = HS_MIX;
      end
      HS_MIX: begin
        if (step_r == 3'd7) hstate_nxt = IsPow2 ? HS_IDLE : HS_MOD;
      end
      HS_MOD: begin
        if (mph_r && (digcnt_r == 3'd5)) hstate_nxt = HS_IDLE;
      end
      default: hstate_nxt = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hstate_r <= HS_IDLE;
      done_r   <= 1'b0;
    end else begin
      hstate_r <= hstate_nxt;
      done_r   <= ((hstate_r == HS_MIX) && (step_r == 3'd7) && IsPow2) ||
                  (in_mod && mph_r && (digcnt_r == 3'd5));
    end
  end

  always_ff @(posedge clk) begin
    unique case (hstate_r)
      HS_IDLE: begin
        step_r <= 3'd0;
        if (start) opnd_r <= key ^ (key >> MIX_S1);
      end
      HS_MIX: begin
        step_r <= step_r + 3'd1;
        unique case (sub)
          2'd0: acc_r <= prod;
          2'd1,
          2'd2: acc_r <= acc_r + {prod[31:0], 32'h0};
          2'd3: begin
            if (!use_c2) begin
              opnd_r <= acc_r ^ (acc_r >> MIX_S2);
            end else begin
              mix_r    <= {8'h00, mix_fin};
              rem_r    <= '0;
              digcnt_r <= '0;
              mph_r    <= 1'b0;
              idx_r    <= mix_fin[IdxW-1:0];
            end
          end
          default: acc_r <= acc_r;
        endcase
      end
      HS_MOD: begin
        mph_r <= !mph_r;
        if (!mph_r) begin
          v_r <= v32;
          q_r <= prod[63:32];
        end else begin
          rem_r    <= rem_fix[IdxW-1:0];
          mix_r    <= {mix_r[59:0], 12'h000};
          digcnt_r <= digcnt_r + 3'd1;
          if (digcnt_r == 3'd5) idx_r <= rem_fix[IdxW-1:0];
        end
      end
      default: step_r <= 3'd0;
    endcase
  end

  assign done  = done_r;
  assign index = idx_r;

endmodule

@@ src/dupf_table.sv @@
module dupf_table
  import dupf_pkg::*;
#(
  parameter int  TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  localparam int IdxW          = $clog2(TABLE_ENTRIES)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [IdxW-1:0] rd_addr,
  output entry_t          rd_data,
  input  logic            wr_en,
  input  logic [IdxW-1:0] wr_addr,
  input  entry_t          wr_data,
  output logic            busy
);

  entry_t          mem [TABLE_ENTRIES];
  entry_t          rd_data_r;
  logic            clr_busy_r;
  logic [IdxW-1:0] clr_addr_r;

  // clearing sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + IdxW'(1);
      if (clr_addr_r == IdxW'(TABLE_ENTRIES - 1)) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

@@ src/first_arrival_duplicate_filter.sv @@
// channel   direction  handshake              payload
// in        slave      in_tvalid/in_tready    tdata: identity, arrival_time, link_slot
//                                             tuser: update_ok
// out       master     out_tvalid/out_tready  tdata: first_seen_time, repeat_delay,
//                                             links_seen; tuser: verdict
// cfg       slave      cfg_tvalid/cfg_tready  tdata: duplicate_window
//
// processing: invalid words and words with zero identity skip the hash and the table;
//   others pass through the shared 32x32 multiplier (six partial products for the
//   two mix multiplies) and the read-modify-write of the single table memory; a
//   table size that is not a power of two adds the remainder, 12 bits at a time by
//   reciprocal multiplication on the same multiplier
// reset: rst_n synchronous, active low; the table is then swept to zero, one entry
//   per cycle, and no word is taken until the sweep is done (cfg still is)
// stalls: a finished result sits in the output register while the next word is taken
module first_arrival_duplicate_filter
  import dupf_pkg::*;
#(
  parameter int  TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  localparam int IdxW          = $clog2(TABLE_ENTRIES)
) (
  input  logic         clk,
  input  logic         rst_n,

  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // identity[63:0], arrival_time[127:64], link_slot[135:128]
  input  logic         in_tuser,   // update_ok

  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // first_seen_time[62:0], repeat_delay[125:63],
                                   // links_seen[133:126], zero[135:134]
  output logic [1:0]   out_tuser,  // verdict

  input  logic         cfg_tvalid,
  output logic         cfg_tready,
  input  logic [63:0]  cfg_tdata   // duplicate_window[62:0], bit 63 ignored
);

  // input word fields
  logic [ID_W-1:0]   in_ident;
  logic [63:0]       in_time;
  logic [LINK_W-1:0] in_slot;
  logic              in_fire;
  logic              in_valid_upd;
  logic [LINK_W-1:0] in_bit;

  // control and held word
  flt_state_t        state_r, state_nxt;
  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] time_r;
  logic [LINK_W-1:0] bit_r;
  logic [TIME_W-1:0] window_r;

  // pending and output result
  result_t           pend_r, pend_nxt;
  logic              pend_load;
  result_t           out_res_r;
  logic              out_valid_r;
  logic              out_load;

  // hash and table
  logic              hash_start;
  logic              hash_done;
  logic [IdxW-1:0]   hash_idx;
  logic              tbl_rd_en;
  entry_t            tbl_rd_data;
  logic              tbl_wr_en;
  entry_t            tbl_wr_data;
  logic              tbl_busy;

  // lookup decision
  logic              same;
  logic              later;
  logic [TIME_W-1:0] gap;
  logic              expired;
  logic              dup;
  logic [TIME_W-1:0] dly;

  assign in_ident = in_tdata[63:0];
  assign in_time  = in_tdata[127:64];
  assign in_slot  = in_tdata[135:128];
  assign in_fire  = in_tvalid && in_tready;
  assign in_bit   = LINK_W'(1) << in_slot[2:0];

  // invalid: flag low, time not positive, slot past the last link
  assign in_valid_upd = in_tuser && !in_time[63] && (in_time != 64'd0) &&
                        (in_slot[7:3] == 5'd0);

  assign in_tready  = (state_r == ST_IDLE) && !tbl_busy;
  assign cfg_tready = 1'b1;

  // window register, zero selects the default
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= DEFAULT_WINDOW;
    end else if (cfg_tvalid && cfg_tready) begin
      window_r <= (cfg_tdata[62:0] == '0) ? DEFAULT_WINDOW : cfg_tdata[62:0];
    end
  end

  // hold the word while the lookup runs
  always_ff @(posedge clk) begin
    if (in_fire) begin
      id_r   <= in_ident;
      time_r <= in_time[62:0];
      bit_r  <= in_bit;
    end
  end

  // stored times and the held time are positive, so 63-bit differences suffice
  assign same    = tbl_rd_data.ident == id_r;
  assign later   = time_r > tbl_rd_data.last_t;
  assign gap     = time_r - tbl_rd_data.last_t;
  assign expired = same && later && (gap > window_r);
  assign dup     = same && !expired;
  assign dly     = (time_r > tbl_rd_data.first_t) ? time_r - tbl_rd_data.first_t : '0;

  always_comb begin
    state_nxt   = state_r;
    pend_nxt    = pend_r;
    pend_load   = 1'b0;
    hash_start  = 1'b0;
    tbl_rd_en   = 1'b0;
    tbl_wr_en   = 1'b0;
    tbl_wr_data = tbl_rd_data;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!in_valid_upd) begin
            pend_nxt  = '{verdict: VERDICT_INVALID, first_seen: '0, delay: '0, links: '0};
            pend_load = 1'b1;
            state_nxt = ST_EMIT;
          end else if (in_ident == '0) begin
            // no identity: accept without a table access
            pend_nxt  = '{verdict: VERDICT_ACCEPT, first_seen: in_time[62:0],
                          delay: '0, links: in_bit};
            pend_load = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            hash_start = 1'b1;
            state_nxt  = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          tbl_rd_en = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        tbl_wr_en = 1'b1;
        pend_load = 1'b1;
        if (dup) begin
          // an earlier arrival than the last keeps the last time
          tbl_wr_data.last_t = later ? time_r : tbl_rd_data.last_t;
          tbl_wr_data.links  = tbl_rd_data.links | bit_r;
          pend_nxt = '{verdict: VERDICT_DUPLICATE, first_seen: tbl_rd_data.first_t,
                       delay: dly, links: tbl_rd_data.links | bit_r};
        end else begin
          // an expired copy of the same identity is a plain accept
          tbl_wr_data = '{ident: id_r, first_t: time_r, last_t: time_r, links: bit_r};
          pend_nxt = '{verdict: ((tbl_rd_data.ident != '0) && !same) ? VERDICT_COLLISION
                                                                     : VERDICT_ACCEPT,
                       first_seen: time_r, delay: '0, links: bit_r};
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) pend_r <= pend_nxt;
    if (out_load) out_res_r <= pend_r;
  end

  dupf_hash #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_ident),
    .done  (hash_done),
    .index (hash_idx)
  );

  // the hash index holds until the next start, so it also serves as write address
  dupf_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (tbl_rd_en),
    .rd_addr (hash_idx),
    .rd_data (tbl_rd_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (hash_idx),
    .wr_data (tbl_wr_data),
    .busy    (tbl_busy)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.verdict;
  assign out_tdata  = {2'b00, out_res_r.links, out_res_r.delay, out_res_r.first_seen};

  // an invalid word carries nothing besides its verdict
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_res_r.verdict == VERDICT_INVALID) |->
      (out_res_r.first_seen == '0) && (out_res_r.delay == '0) && (out_res_r.links == '0))
    else $error("invalid result carries payload");

  // only a duplicate has a delay, and a fresh entry names exactly one link
  a_fresh_one_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_res_r.verdict == VERDICT_ACCEPT) ||
                   (out_res_r.verdict == VERDICT_COLLISION)) |->
      $onehot(out_res_r.links) && (out_res_r.delay == '0))
    else $error("fresh entry result malformed");

  // hash result lands only while the lookup waits for it
  a_hash_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> (state_r == ST_HASH))
    else $error("hash result outside hash wait");

  // table is never written by the lookup while the sweep runs, nor without a read before it
  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr_en |-> !tbl_busy && $past(tbl_rd_en))
    else $error("table write during sweep or without read");

endmodule

@@ sim/first_arrival_duplicate_filter_test.sv @@
`timescale 1ns / 1ps

module first_arrival_duplicate_filter_test;
  import dupf_pkg::*;

  localparam int          TABLE_ENTRIES = DEF_TABLE_ENTRIES;
  localparam int          ENTRY_W       = $clog2(TABLE_ENTRIES);
  localparam int          LINK_COUNT    = 8;
  localparam int          POOL_DEPTH    = 24;
  localparam int          RESET_CYCLES  = 8;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          PHASE_WORDS   = 158;
  localparam int          HOLD_CYCLES   = 400;
  localparam longint      TIME_MAX      = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] SIGN_BIT      = 64'h8000_0000_0000_0000;

  // kinds of malformed words mixed into the traffic
  typedef enum int {
    NOISE_FLAG_LOW,
    NOISE_BAD_TIME,
    NOISE_BAD_LINK,
    NOISE_ANY
  } noise_kind_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata   = '0;  // identity[63:0], arrival_time[127:64], link_slot[135:128]
  logic         in_tuser   = 1'b0;  // update_ok
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;  // first_seen_time[62:0], repeat_delay[125:63], links_seen[133:126]
  logic [1:0]   out_tuser;  // verdict
  logic         cfg_tvalid = 1'b0;
  logic         cfg_tready;
  logic [63:0]  cfg_tdata  = '0;  // duplicate_window[62:0]

  // shadow copy of the filter table and window
  logic [ID_W-1:0]   tbl_ident [TABLE_ENTRIES];
  longint            tbl_first [TABLE_ENTRIES];
  longint            tbl_last  [TABLE_ENTRIES];
  logic [LINK_W-1:0] tbl_links [TABLE_ENTRIES];
  logic [TIME_W-1:0] window_ns;

  result_t         expected_results[$];
  logic [ID_W-1:0] id_pool[$];
  longint          now_ns            = 1;
  bit              sender_gaps       = 1'b1;
  bit              sink_gaps         = 1'b1;
  int              sink_hold_request = 0;
  int              mismatch_count    = 0;

  first_arrival_duplicate_filter #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata)
  );

  always #1 clk = ~clk;

  // mostly back to back, some short pauses, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // splitmix64 finalizer, reduced to a table index
  function automatic logic [ENTRY_W-1:0] table_entry(input logic [ID_W-1:0] ident);
    logic [63:0] v;
    v = ident;
    v = v ^ (v >> MIX_S1);
    v = v * MIX_C1;
    v = v ^ (v >> MIX_S2);
    v = v * MIX_C2;
    v = v ^ (v >> MIX_S3);
    return ENTRY_W'(v % TABLE_ENTRIES);
  endfunction

  // a different nonzero identity that lands on the same table entry
  function automatic logic [ID_W-1:0] twin_identity(input logic [ID_W-1:0] ident);
    logic [ID_W-1:0] cand;
    logic [ENTRY_W-1:0] k;
    k = table_entry(ident);
    forever begin
      cand = {$urandom, $urandom};
      if (cand != '0 && cand != ident && table_entry(cand) == k) return cand;
    end
  endfunction

  // verdict for one word, updating the shadow table as the block should
  function automatic result_t predict_update(input logic [ID_W-1:0] ident,
                                             input logic [63:0] arrival_raw,
                                             input logic ok, input logic [7:0] slot);
    result_t r;
    longint t;
    longint d;
    logic [ENTRY_W-1:0] k;
    logic [LINK_W-1:0] link_bit;
    logic [63:0] since_last;
    logic same;
    logic expired;
    r = '0;
    t = arrival_raw;
    // invalid words leave every other field at zero
    if (!ok || t <= 0 || slot >= LINK_COUNT) return r;
    link_bit = 8'd1 << slot;
    // no identity: accepted without a table lookup
    if (ident == '0) begin
      r.verdict    = VERDICT_ACCEPT;
      r.first_seen = t[TIME_W-1:0];
      r.links      = link_bit;
      return r;
    end
    k          = table_entry(ident);
    same       = (tbl_ident[k] == ident);
    since_last = t - tbl_last[k];
    // an arrival earlier than the last one never expires
    expired    = same && t > tbl_last[k] && since_last > {1'b0, window_ns};
    if (same && !expired) begin
      d = t - tbl_first[k];
      if (t > tbl_last[k]) tbl_last[k] = t;
      tbl_links[k] = tbl_links[k] | link_bit;
      r.verdict    = VERDICT_DUPLICATE;
      r.first_seen = tbl_first[k][TIME_W-1:0];
      r.delay      = (d > 0) ? d[TIME_W-1:0] : '0;
      r.links      = tbl_links[k];
      return r;
    end
    if (tbl_ident[k] != '0 && !same) r.verdict = VERDICT_COLLISION;
    else r.verdict = VERDICT_ACCEPT;
    tbl_ident[k] = ident;
    tbl_first[k] = t;
    tbl_last[k]  = t;
    tbl_links[k] = link_bit;
    r.first_seen = t[TIME_W-1:0];
    r.links      = link_bit;
    return r;
  endfunction

  // offers one word; valid stays high on return so a following word can go back to back
  task automatic send_update(input logic [ID_W-1:0] ident, input logic [63:0] arrival,
                             input logic ok, input logic [7:0] slot);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {slot, arrival, ident};
    in_tuser  <= ok;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_update(ident, arrival, ok, slot));
  endtask

  // stop offering and let every outstanding verdict come back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [63:0] value);
    wait_results_drained();
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= value;
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
    // bit 63 is dropped and zero falls back to the default window
    window_ns = (value[TIME_W-1:0] == '0) ? DEFAULT_WINDOW : value[TIME_W-1:0];
  endtask

  function automatic void remember_identity(input logic [ID_W-1:0] ident);
    id_pool.push_back(ident);
    if (id_pool.size() > POOL_DEPTH) void'(id_pool.pop_front());
  endfunction

  function automatic logic [ID_W-1:0] pooled_identity();
    if (id_pool.size() == 0) return {$urandom, $urandom};
    return id_pool[$urandom_range(0, id_pool.size() - 1)];
  endfunction

  // time step scaled to the current window so repeats land on both sides of it
  function automatic longint time_advance();
    longint w;
    int r;
    w = longint'({1'b0, window_ns});
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 3);
    if (r < 80) begin
      if (w <= 64'hffff_ffff) return $urandom_range(0, int'(w));
      return {$urandom};
    end
    if (w < 64'h1000_0000_0000) return w + $urandom_range(1, 1000);
    return $urandom_range(1, 1000);
  endfunction

  task automatic send_noise_update();
    noise_kind_t kind;
    logic [ID_W-1:0] ident;
    logic [63:0] arrival;
    logic [7:0] slot;
    logic ok;
    kind    = noise_kind_t'($urandom_range(0, 3));
    ident   = ($urandom_range(0, 1) == 0) ? pooled_identity() : {$urandom, $urandom};
    arrival = now_ns;
    ok      = 1'b1;
    slot    = $urandom_range(0, LINK_COUNT - 1);
    case (kind)
      NOISE_FLAG_LOW: ok = 1'b0;
      NOISE_BAD_TIME: begin
        // zero or negative receive time
        if ($urandom_range(0, 3) == 0) arrival = '0;
        else arrival = SIGN_BIT | {$urandom, $urandom};
      end
      NOISE_BAD_LINK: slot = $urandom_range(LINK_COUNT, 255);
      default: begin
        arrival = {$urandom, $urandom};
        ok      = $urandom_range(0, 1);
        slot    = $urandom_range(0, 255);
      end
    endcase
    send_update(ident, arrival, ok, slot);
  endtask

  // one word of realistic traffic: malformed words, repeats from a small pool, fresh and
  // colliding identities, the occasional missing identity, late arrivals and window-edge hits
  task automatic send_traffic_update();
    int pick;
    int aim;
    logic [ID_W-1:0] ident;
    logic [ENTRY_W-1:0] k;
    longint arrival;
    longint w;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_noise_update();
      return;
    end
    if (pick < 15) begin
      ident = '0;
    end else if (pick < 25 || id_pool.size() == 0) begin
      ident = {$urandom, $urandom};
      remember_identity(ident);
    end else if (pick < 33) begin
      ident = twin_identity(pooled_identity());
      remember_identity(ident);
    end else begin
      ident = pooled_identity();
    end
    w   = longint'({1'b0, window_ns});
    k   = table_entry(ident);
    aim = $urandom_range(0, 99);
    if (aim < 15 && ident != '0 && tbl_ident[k] == ident && TIME_MAX - tbl_last[k] > w) begin
      // exactly at the window edge or one past it
      arrival = tbl_last[k] + w + $urandom_range(0, 1);
    end else if (aim < 25) begin
      // arrival earlier than the current time
      arrival = now_ns - $urandom_range(1, 1000);
      if (arrival <= 0) arrival = 1;
    end else begin
      now_ns = now_ns + time_advance();
      if (now_ns > 64'h4000_0000_0000_0000) now_ns = 1 + $urandom_range(0, 1000);
      arrival = now_ns;
    end
    send_update(ident, arrival, 1'b1, $urandom_range(0, LINK_COUNT - 1));
  endtask

  // extremes of every field, invalid words and the missing identity
  task automatic test_field_extremes();
    send_update('1, TIME_MAX, 1'b0, 8'd0);
    send_update({$urandom, $urandom}, 64'd0, 1'b1, 8'd1);
    send_update({$urandom, $urandom}, SIGN_BIT, 1'b1, 8'd2);
    send_update({$urandom, $urandom}, '1, 1'b1, 8'd3);
    send_update({$urandom, $urandom}, 64'd77, 1'b1, 8'd8);
    send_update('1, 64'd78, 1'b1, 8'd255);
    send_update('0, TIME_MAX, 1'b1, 8'd7);
    send_update('0, 64'd1, 1'b0, 8'd0);
  endtask

  // duplicate, expiry, late arrival and collision under the default window
  task automatic test_repeat_and_expiry();
    logic [ID_W-1:0] first_id;
    logic [ID_W-1:0] rival_id;
    logic [ID_W-1:0] late_id;
    longint w;
    w        = longint'({1'b0, DEFAULT_WINDOW});
    first_id = '1;
    rival_id = twin_identity(first_id);
    late_id  = {$urandom, $urandom} | 64'd1;
    send_update(first_id, 64'd1, 1'b1, 8'd0);
    // gap equal to the window is still a duplicate
    send_update(first_id, 1 + w, 1'b1, 8'd3);
    send_update(first_id, 1 + w - 5, 1'b1, 8'd5);
    // one past the window expires the entry
    send_update(first_id, 2 + 2 * w, 1'b1, 8'd6);
    send_update(rival_id, 3 + 2 * w, 1'b1, 8'd1);
    send_update(first_id, 4 + 2 * w, 1'b1, 8'd2);
    // earlier than the first arrival: delay clamps at zero
    send_update(late_id, 64'd1000, 1'b1, 8'd4);
    send_update(late_id, 64'd400, 1'b1, 8'd4);
  endtask

  task automatic test_window_register();
    logic [ID_W-1:0] short_id;
    logic [ID_W-1:0] long_id;
    short_id = {$urandom, $urandom} | 64'd2;
    long_id  = {$urandom, $urandom} | 64'd4;
    write_window(64'd1);
    send_update(short_id, 64'd100, 1'b1, 8'd0);
    send_update(short_id, 64'd101, 1'b1, 8'd1);
    send_update(short_id, 64'd103, 1'b1, 8'd2);
    write_window(TIME_MAX);
    send_update(long_id, 64'd1, 1'b1, 8'd0);
    send_update(long_id, TIME_MAX, 1'b1, 8'd7);
    // top bit of the write is ignored, leaving a window of three
    write_window(SIGN_BIT | 64'd3);
    send_update(short_id, 64'd106, 1'b1, 8'd5);
    write_window(64'd0);
  endtask

  // receiver stalls for a long stretch while words keep coming, then the sender
  // waits for everything to drain
  task automatic test_backpressure();
    int i;
    sender_gaps       = 1'b0;
    sink_hold_request = HOLD_CYCLES;
    for (i = 0; i < 24; i++) send_traffic_update();
    wait_results_drained();
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [63:0] phase_window [6];
    int p;
    int i;
    phase_window[0] = 64'd0;
    phase_window[1] = 64'd1;
    phase_window[2] = TIME_MAX;
    phase_window[3] = $urandom_range(2, 50);
    phase_window[4] = SIGN_BIT | $urandom_range(100, 5000);
    phase_window[5] = {32'd0, $urandom} | 64'd1;
    for (p = 0; p < 6; p++) begin
      write_window(phase_window[p]);
      // phase 3 runs with no idling on either side
      sender_gaps = !(p == 1 || p == 3);
      sink_gaps   = !(p == 2 || p == 3);
      for (i = 0; i < PHASE_WORDS; i++) send_traffic_update();
    end
    sender_gaps = 1'b1;
    sink_gaps   = 1'b1;
  endtask

  // receiver: random stalls, plus one long hold when asked
  initial begin : result_sink
    int stretch;
    forever begin
      @(posedge clk);
      stretch = 0;
      if (sink_hold_request > 0) begin
        stretch           = sink_hold_request;
        sink_hold_request = 0;
      end else if (sink_gaps && $urandom_range(0, 2) == 0) begin
        stretch = pick_gap();
      end
      if (stretch > 0) begin
        out_tready <= 1'b0;
        repeat (stretch) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // every result word against the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: tuser %0d tdata %h", out_tuser, out_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[62:0] !== want.first_seen) begin
          $error("first_seen_time: expected %0d, got %0d", want.first_seen, out_tdata[62:0]);
          mismatch_count++;
        end
        if (out_tdata[125:63] !== want.delay) begin
          $error("repeat_delay: expected %0d, got %0d", want.delay, out_tdata[125:63]);
          mismatch_count++;
        end
        if (out_tdata[133:126] !== want.links) begin
          $error("links_seen: expected %h, got %h", want.links, out_tdata[133:126]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : main
    int i;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_ident[i] = '0;
      tbl_first[i] = 0;
      tbl_last[i]  = 0;
      tbl_links[i] = '0;
    end
    window_ns = DEFAULT_WINDOW;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    // the table sweep after reset holds off input until it is done
    test_field_extremes();
    test_repeat_and_expiry();
    test_window_register();
    test_backpressure();
    test_random_traffic();
    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #1_500_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
src/dupf_pkg.sv
src/dupf_hash.sv
src/dupf_table.sv
src/first_arrival_duplicate_filter.sv
sim/first_arrival_duplicate_filter_test.sv
